// ===== design/runs_above_below_test_defines.svh =====
// ----------------------------------------------------------------------------
// Runs test assertion macros
// Shared shorthand for the concurrent checks in the runs test design.
// ----------------------------------------------------------------------------
`ifndef RUNS_ABOVE_BELOW_TEST_DEFINES_SVH
`define RUNS_ABOVE_BELOW_TEST_DEFINES_SVH

// A property that is checked on every clock edge outside of reset.
`define RABT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must be followed by an expression on the next edge.
`define RABT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== design/rabt_pkg.sv =====
// ----------------------------------------------------------------------------
// Runs test package
// Widths, register codes and shared types of the runs above and below test.
// ----------------------------------------------------------------------------
package rabt_pkg;

  // Field and register widths.
  localparam int unsigned SAMPLE_BITS   = 10;
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned THR_BITS      = 10;
  localparam int unsigned CZ_BITS       = 12;
  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 12;

  // Widths of the verdict and compare arithmetic, derived from the count, fraction, sample and threshold widths.
  localparam int unsigned N_BITS    = COUNT_BITS + 1;
  localparam int unsigned PROD_BITS = 2 * COUNT_BITS;
  localparam int unsigned VT_BITS   = 2 * COUNT_BITS + 1;
  localparam int unsigned D_BITS    = 2 * COUNT_BITS + 3;
  localparam int unsigned WIDE_BITS = 2 * D_BITS + N_BITS + FRAC_BITS;
  localparam int unsigned OPB_BITS  = D_BITS;
  localparam int unsigned CMP_BITS  =
    ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Register reset values.
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(500);
  localparam logic [CZ_BITS-1:0]  CZ_RESET  = CZ_BITS'(983);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CRIT_ZSQ  = CFG_IDX_BITS'(1);

  // Class of the previous sample.
  typedef enum logic [1:0] {
    SIDE_NONE,
    SIDE_ABOVE,
    SIDE_BELOW
  } side_e;

  // Verdict sequencer states.
  typedef enum logic [2:0] {
    V_IDLE,
    V_PROD,
    V_NR,
    V_DD,
    V_LHS,
    V_CZ,
    V_RHS,
    V_DONE
  } verdict_state_e;

  // Counts of one sequence.
  typedef struct packed {
    logic [COUNT_BITS-1:0] runs;
    logic [COUNT_BITS-1:0] above;
    logic [COUNT_BITS-1:0] below;
    logic                  overflow;
  } tally_t;

  // Status of the shared multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== design/rabt_if.sv =====
// ----------------------------------------------------------------------------
// Runs test channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------

// Sample channel: one request carries one sample.
interface rabt_sample_if;
  logic                             valid;
  logic                             ready;
  logic [rabt_pkg::SAMPLE_BITS-1:0] sample;
  logic                             last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// Result channel: one request per finished sequence.
interface rabt_result_if;
  logic                            valid;
  logic                            ready;
  logic                            accept;
  logic [rabt_pkg::COUNT_BITS-1:0] run_count;
  logic [rabt_pkg::COUNT_BITS-1:0] above_count;
  logic [rabt_pkg::COUNT_BITS-1:0] below_count;
  logic                            count_overflow;

  modport source (output valid, output accept, output run_count, output above_count,
                  output below_count, output count_overflow, input ready);
  modport sink (input valid, input accept, input run_count, input above_count,
                input below_count, input count_overflow, output ready);
endinterface

// Register write channel.
interface rabt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rabt_pkg::CFG_IDX_BITS-1:0]  idx;
  logic [rabt_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== design/rabt_mul.sv =====
// ----------------------------------------------------------------------------
// Runs test shift-add multiplier
// Shared multiplier that adds one shifted partial product per cycle.
// ----------------------------------------------------------------------------
module rabt_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rabt_pkg::WIDE_BITS-1:0] a_i,
  input  logic [rabt_pkg::OPB_BITS-1:0]  b_i,
  output rabt_pkg::mul_stat_t            stat_o,
  output logic [rabt_pkg::WIDE_BITS-1:0] prod_o
);

  logic                          busy_q;
  logic [rabt_pkg::WIDE_BITS-1:0] a_q;
  logic [rabt_pkg::OPB_BITS-1:0]  b_q;
  logic [rabt_pkg::WIDE_BITS-1:0] acc_q;

  // The product is complete once every multiplier bit has been consumed.
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (b_q == '0);
  assign prod_o      = acc_q;

  // Busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  // Operand and accumulator registers: one multiplier bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[rabt_pkg::WIDE_BITS-2:0], 1'b0};
      b_q <= {1'b0, b_q[rabt_pkg::OPB_BITS-1:1]};
    end
  end

endmodule

// ===== design/rabt_verdict.sv =====
// ----------------------------------------------------------------------------
// Runs test verdict sequencer
// Forms both sides of the squared Z comparison on the shared multiplier.
// ----------------------------------------------------------------------------
`include "runs_above_below_test_defines.svh"

module rabt_verdict (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rabt_pkg::tally_t            tally_i,
  input  logic [rabt_pkg::CZ_BITS-1:0] cz_i,
  input  logic                        take_i,
  output logic                        done_o,
  output logic                        accept_o,
  output rabt_pkg::tally_t            tally_o
);

  rabt_pkg::verdict_state_e state_q, state_d;

  rabt_pkg::tally_t                tally_q;
  logic [rabt_pkg::N_BITS-1:0]     n_q;
  logic [rabt_pkg::PROD_BITS-1:0]  prod_q;
  logic [rabt_pkg::CZ_BITS-1:0]    cz_q;
  logic [rabt_pkg::WIDE_BITS-1:0]  lhs_q;
  logic                            accept_q, accept_d;

  logic                            mul_start;
  logic [rabt_pkg::WIDE_BITS-1:0]  mul_a;
  logic [rabt_pkg::OPB_BITS-1:0]   mul_b;
  rabt_pkg::mul_stat_t             mul_stat;
  logic [rabt_pkg::WIDE_BITS-1:0]  mul_p;

  logic                            bad_start;
  logic [rabt_pkg::N_BITS-1:0]     n_start;
  logic [rabt_pkg::VT_BITS-1:0]    two_prod;
  logic [rabt_pkg::VT_BITS-1:0]    n_vt;
  logic                            degen;
  logic [rabt_pkg::VT_BITS-1:0]    vterm;
  logic [rabt_pkg::D_BITS-1:0]     p_nr;
  logic [rabt_pkg::D_BITS-1:0]     q_nr;
  logic [rabt_pkg::D_BITS-1:0]     diff;

  rabt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (mul_p)
  );

  // Screening of the sequence and the terms built between products.
  always_comb begin
    bad_start = tally_i.overflow || (tally_i.above == '0) || (tally_i.below == '0);
    n_start   = rabt_pkg::N_BITS'(tally_i.above) + rabt_pkg::N_BITS'(tally_i.below);
    two_prod  = {mul_p[rabt_pkg::PROD_BITS-1:0], 1'b0};
    n_vt      = rabt_pkg::VT_BITS'(n_q);
    degen     = (two_prod <= n_vt);
    vterm     = {prod_q, 1'b0} - n_vt;
    p_nr      = rabt_pkg::D_BITS'({mul_p[rabt_pkg::N_BITS+rabt_pkg::COUNT_BITS-1:0], 1'b0});
    q_nr      = rabt_pkg::D_BITS'({prod_q, 2'b00}) + rabt_pkg::D_BITS'(n_q);
    diff      = (p_nr > q_nr) ? (p_nr - q_nr) : (q_nr - p_nr);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rabt_pkg::V_IDLE: begin
        if (start_i) begin
          state_d = bad_start ? rabt_pkg::V_DONE : rabt_pkg::V_PROD;
        end
      end
      rabt_pkg::V_PROD: begin
        if (mul_stat.done) begin
          state_d = degen ? rabt_pkg::V_DONE : rabt_pkg::V_NR;
        end
      end
      rabt_pkg::V_NR: begin
        if (mul_stat.done) begin
          state_d = rabt_pkg::V_DD;
        end
      end
      rabt_pkg::V_DD: begin
        if (mul_stat.done) begin
          state_d = rabt_pkg::V_LHS;
        end
      end
      rabt_pkg::V_LHS: begin
        if (mul_stat.done) begin
          state_d = rabt_pkg::V_CZ;
        end
      end
      rabt_pkg::V_CZ: begin
        if (mul_stat.done) begin
          state_d = rabt_pkg::V_RHS;
        end
      end
      rabt_pkg::V_RHS: begin
        if (mul_stat.done) begin
          state_d = rabt_pkg::V_DONE;
        end
      end
      rabt_pkg::V_DONE: begin
        if (take_i) begin
          state_d = rabt_pkg::V_IDLE;
        end
      end
      default: state_d = rabt_pkg::V_IDLE;
    endcase
  end

  // Multiplier operands and the verdict bit for each step.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    accept_d  = accept_q;
    done_o    = 1'b0;
    unique case (state_q)
      rabt_pkg::V_IDLE: begin
        // n1 * n2
        if (start_i) begin
          accept_d  = 1'b0;
          mul_start = !bad_start;
          mul_a     = rabt_pkg::WIDE_BITS'(tally_i.above);
          mul_b     = rabt_pkg::OPB_BITS'(tally_i.below);
        end
      end
      rabt_pkg::V_PROD: begin
        // n * R
        if (mul_stat.done) begin
          accept_d  = 1'b0;
          mul_start = !degen;
          mul_a     = rabt_pkg::WIDE_BITS'(n_q);
          mul_b     = rabt_pkg::OPB_BITS'(tally_q.runs);
        end
      end
      rabt_pkg::V_NR: begin
        // D * D
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = rabt_pkg::WIDE_BITS'(diff);
          mul_b     = rabt_pkg::OPB_BITS'(diff);
        end
      end
      rabt_pkg::V_DD: begin
        // D * D * (n - 1)
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mul_p;
          mul_b     = rabt_pkg::OPB_BITS'(n_q - rabt_pkg::N_BITS'(1));
        end
      end
      rabt_pkg::V_LHS: begin
        // n1 * n2 * critical value
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = rabt_pkg::WIDE_BITS'(prod_q);
          mul_b     = rabt_pkg::OPB_BITS'(cz_q);
        end
      end
      rabt_pkg::V_CZ: begin
        // Times eight, times the variance term.
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = {mul_p[rabt_pkg::WIDE_BITS-4:0], 3'b000};
          mul_b     = rabt_pkg::OPB_BITS'(vterm);
        end
      end
      rabt_pkg::V_RHS: begin
        if (mul_stat.done) begin
          accept_d = (lhs_q <= mul_p);
        end
      end
      rabt_pkg::V_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  // State and verdict bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rabt_pkg::V_IDLE;
      accept_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      accept_q <= accept_d;
    end
  end

  // Operands of the sequence and intermediate products.
  always_ff @(posedge clk_i) begin
    if ((state_q == rabt_pkg::V_IDLE) && start_i) begin
      tally_q <= tally_i;
      n_q     <= n_start;
      cz_q    <= cz_i;
    end
    if ((state_q == rabt_pkg::V_PROD) && mul_stat.done) begin
      prod_q <= mul_p[rabt_pkg::PROD_BITS-1:0];
    end
    if ((state_q == rabt_pkg::V_LHS) && mul_stat.done) begin
      lhs_q <= {mul_p[rabt_pkg::WIDE_BITS-rabt_pkg::FRAC_BITS-1:0],
                {rabt_pkg::FRAC_BITS{1'b0}}};
    end
  end

  assign accept_o = accept_q;
  assign tally_o  = tally_q;

  // Checks.
  `RABT_ASSERT(a_start_idle, start_i |-> (state_q == rabt_pkg::V_IDLE), "verdict started while busy")
  `RABT_ASSERT(a_mul_free, mul_start |-> (!mul_stat.busy || mul_stat.done), "multiplier restarted mid product")
  `RABT_ASSERT(a_ovf_reject, (done_o && tally_q.overflow) |-> !accept_q, "saturated sequence accepted")

endmodule

// ===== design/runs_above_below_test.sv =====
// ----------------------------------------------------------------------------
// Runs above and below the midpoint test
// Each sample is classed against the midpoint threshold and counted as it is
// accepted, so samples are taken at one per cycle while no verdict is pending.
// The sample marked last closes the sequence. Its counts go to a verdict
// sequencer that forms the squared Z comparison on one shift-add multiplier,
// one multiplier bit per cycle. The block then takes no sample until that
// verdict is moved into the output register. That gap is set by the bit
// lengths of the six multiplier operands. No product is formed when a count
// is zero or saturated, and only the first when both counts are one. The
// result register lets the next sequence start while a result still waits
// to be taken. A verdict that finds the result register still full waits,
// and holds off samples, until the register is free.
// ----------------------------------------------------------------------------
`include "runs_above_below_test_defines.svh"

module runs_above_below_test (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rabt_sample_if.sink          smp_i,
  rabt_result_if.source        res_o,
  rabt_cfg_if.sink             cfg_i
);

  logic [rabt_pkg::THR_BITS-1:0]   thr_q;
  logic [rabt_pkg::CZ_BITS-1:0]    cz_q;

  rabt_pkg::side_e                 prev_q, side_new;
  logic [rabt_pkg::COUNT_BITS-1:0] runs_q, above_q, below_q;
  logic                            ovf_q;
  logic                            busy_q;
  logic                            out_valid_q;
  logic                            out_accept_q;
  rabt_pkg::tally_t                out_tally_q;

  logic                            smp_acc;
  logic                            is_above;
  logic                            run_bump;
  rabt_pkg::tally_t                tally_nx;
  logic                            vd_done;
  logic                            vd_accept;
  rabt_pkg::tally_t                vd_tally;
  logic                            vd_take;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rabt_pkg::THR_RESET;
      cz_q  <= rabt_pkg::CZ_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        rabt_pkg::REG_THRESHOLD: thr_q <= cfg_i.data[rabt_pkg::THR_BITS-1:0];
        rabt_pkg::REG_CRIT_ZSQ:  cz_q  <= cfg_i.data[rabt_pkg::CZ_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sample handshake.
  assign smp_i.ready = !busy_q;
  assign smp_acc     = smp_i.valid && !busy_q;

  // Classify the sample and update the saturating counts.
  always_comb begin
    is_above = (rabt_pkg::CMP_BITS'(smp_i.sample) >= rabt_pkg::CMP_BITS'(thr_q));
    side_new = is_above ? rabt_pkg::SIDE_ABOVE : rabt_pkg::SIDE_BELOW;
    run_bump = (side_new != prev_q);

    tally_nx.runs     = runs_q;
    tally_nx.above    = above_q;
    tally_nx.below    = below_q;
    tally_nx.overflow = ovf_q;
    if (run_bump) begin
      if (runs_q == rabt_pkg::COUNT_MAX) begin
        tally_nx.overflow = 1'b1;
      end else begin
        tally_nx.runs = runs_q + rabt_pkg::COUNT_BITS'(1);
      end
    end
    if (is_above) begin
      if (above_q == rabt_pkg::COUNT_MAX) begin
        tally_nx.overflow = 1'b1;
      end else begin
        tally_nx.above = above_q + rabt_pkg::COUNT_BITS'(1);
      end
    end else begin
      if (below_q == rabt_pkg::COUNT_MAX) begin
        tally_nx.overflow = 1'b1;
      end else begin
        tally_nx.below = below_q + rabt_pkg::COUNT_BITS'(1);
      end
    end
  end

  // Sequence counters; the last sample hands its counts over and clears them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= rabt_pkg::SIDE_NONE;
      runs_q  <= '0;
      above_q <= '0;
      below_q <= '0;
      ovf_q   <= 1'b0;
    end else if (smp_acc) begin
      if (smp_i.last_sample) begin
        prev_q  <= rabt_pkg::SIDE_NONE;
        runs_q  <= '0;
        above_q <= '0;
        below_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        prev_q  <= side_new;
        runs_q  <= tally_nx.runs;
        above_q <= tally_nx.above;
        below_q <= tally_nx.below;
        ovf_q   <= tally_nx.overflow;
      end
    end
  end

  rabt_verdict u_verdict (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (smp_acc && smp_i.last_sample),
    .tally_i (tally_nx),
    .cz_i    (cz_q),
    .take_i  (vd_take),
    .done_o  (vd_done),
    .accept_o(vd_accept),
    .tally_o (vd_tally)
  );

  // The verdict moves into the result register once that register is free.
  assign vd_take = vd_done && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (smp_acc && smp_i.last_sample) begin
        busy_q <= 1'b1;
      end else if (vd_take) begin
        busy_q <= 1'b0;
      end
      if (vd_take) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vd_take) begin
      out_accept_q <= vd_accept;
      out_tally_q  <= vd_tally;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.accept         = out_accept_q;
  assign res_o.run_count      = out_tally_q.runs;
  assign res_o.above_count    = out_tally_q.above;
  assign res_o.below_count    = out_tally_q.below;
  assign res_o.count_overflow = out_tally_q.overflow;

  // Checks.
  `RABT_ASSERT_NEXT(a_last_busy, smp_acc && smp_i.last_sample, busy_q, "last sample did not stall input")
  `RABT_ASSERT(a_busy_clear, busy_q |-> (prev_q == rabt_pkg::SIDE_NONE), "counts not cleared after last sample")
  `RABT_ASSERT(a_runs_bound, !ovf_q |-> (rabt_pkg::N_BITS'(runs_q) <= (rabt_pkg::N_BITS'(above_q) + rabt_pkg::N_BITS'(below_q))), "more runs than samples")

endmodule
